// ----- rtl/spwm_pkg.sv -----
// Shared types and constants for the half-sine SPWM compare generator.
// No dependencies; used by every module of the block.
package spwm_pkg;

  // Field and register widths
  localparam int unsigned PHASE_W   = 32;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned AMP_W     = 11;
  localparam int unsigned ROM_W     = 13;
  localparam int unsigned SCALED_W  = 17;
  localparam int unsigned CMP_W     = 16;
  localparam int unsigned MUL_A_W   = 17;
  localparam int unsigned MUL_B_W   = 16;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 1'd1;

  // Configuration reset values
  localparam logic [PHASE_W-1:0]  PHASE_INC_RST  = 32'd42949650;
  localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST = 16'd1600;

  // Amplitude scaling: amp = pct*1024/100 = (pct*5243) >> 9 for pct <= 100
  localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
  localparam int unsigned      AMP_PROD_W = 20;
  localparam logic [AMP_PROD_W-1:0] AMP_RECIP = 20'd5243;

  // Sequencer steps
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_ADDR,
    SEQ_SCALE,
    SEQ_AMP
  } seq_state_t;

endpackage

// ----- rtl/spwm_rom.sv -----
// Half-sine lookup: maps the phase to a table index and reads the table
// with a registered output. Table contents are built at elaboration.
// Depends on spwm_pkg.
module spwm_rom #(
  parameter int unsigned TABLE_ENTRIES = 512
) (
  input  logic                          clk,
  input  logic [spwm_pkg::PHASE_W-1:0]  phase,
  output logic [spwm_pkg::ROM_W-1:0]    rom_data
);

  localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int unsigned PROD_W = spwm_pkg::PHASE_W + IDX_W + 1;

  typedef logic [spwm_pkg::ROM_W-1:0] rom_arr_t [TABLE_ENTRIES];

  // (a*b) >> 60 built from 32-bit halves, truncating each piece
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah, al, bh, bl, mid;
    ah  = a >> 32;
    al  = a & 64'hFFFF_FFFF;
    bh  = b >> 32;
    bl  = b & 64'hFFFF_FFFF;
    mid = ah * bl + al * bh;
    return ah * bh * 64'd16 + (mid >> 28) + ((al * bl) >> 60);
  endfunction

  // Unsigned quotient by shift and subtract, used to build the table
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // round(sin(k*pi/TABLE_ENTRIES)*4096) by a Q60 Taylor series
  function automatic logic [spwm_pkg::ROM_W-1:0] sine_entry(input logic [63:0] k);
    logic [63:0] ratio, x, x2, term, sum, n;
    logic        neg;
    ratio = div_u64(k << 52, 64'(TABLE_ENTRIES)) << 8;
    x     = mul_q60(64'h3243_F6A8_885A_308D, ratio);
    x2    = mul_q60(x, x);
    term  = x;
    sum   = x;
    n     = 64'd1;
    neg   = 1'b1;
    for (int j = 0; j < 30; j++) begin
      if (term != 64'd0) begin
        term = div_u64(mul_q60(term, x2), (n + 64'd1) * (n + 64'd2));
        if (neg) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
        neg = !neg;
        n   = n + 64'd2;
      end
    end
    if (sum > (64'd1 << 60)) begin
      sum = 64'd1 << 60;
    end
    return spwm_pkg::ROM_W'((sum + (64'd1 << 47)) >> 48);
  endfunction

  function automatic rom_arr_t build_rom();
    rom_arr_t    tbl;
    logic [63:0] k;
    for (int i = 0; i < int'(TABLE_ENTRIES); i++) begin
      if (2 * i > int'(TABLE_ENTRIES)) begin
        k = 64'(TABLE_ENTRIES - i);
      end else begin
        k = 64'(i);
      end
      tbl[i] = sine_entry(k);
    end
    return tbl;
  endfunction

  localparam rom_arr_t SINE_ROM = build_rom();

  logic [PROD_W-1:0] idx_prod;
  logic [IDX_W-1:0]  rom_addr;

  // Scale phase to table index: (phase * TABLE_ENTRIES) >> 32
  assign idx_prod = PROD_W'(phase) * PROD_W'(TABLE_ENTRIES);
  assign rom_addr = idx_prod[spwm_pkg::PHASE_W +: IDX_W];

  // Registered table read
  always_ff @(posedge clk) begin
    rom_data <= SINE_ROM[rom_addr];
  end

endmodule

// ----- rtl/spwm_mul_unit.sv -----
// Shared multiplier of the compare path with its operand selection.
// Used once for period scaling and once for amplitude scaling. Depends on spwm_pkg.
module spwm_mul_unit (
  input  spwm_pkg::seq_state_t             step,
  input  logic [spwm_pkg::ROM_W-1:0]       rom_data,
  input  logic [spwm_pkg::PERIOD_W-1:0]    pwm_period,
  input  logic [spwm_pkg::SCALED_W-1:0]    scaled,
  input  logic [spwm_pkg::AMP_W-1:0]       amp,
  output logic [spwm_pkg::MUL_P_W-1:0]     product
);

  logic [spwm_pkg::MUL_A_W-1:0] op_a;
  logic [spwm_pkg::MUL_B_W-1:0] op_b;

  // Pick operands for the current step
  always_comb begin
    case (step)
      spwm_pkg::SEQ_SCALE: begin
        op_a = spwm_pkg::MUL_A_W'(rom_data);
        op_b = pwm_period;
      end
      spwm_pkg::SEQ_AMP: begin
        op_a = scaled;
        op_b = spwm_pkg::MUL_B_W'(amp);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign product = spwm_pkg::MUL_P_W'(op_a) * spwm_pkg::MUL_P_W'(op_b);

endmodule

// ----- rtl/spwm_half_sine_generator.sv -----
// Half-sine SPWM compare generator. Each request is one PWM-period tick with an
// amplitude in percent (values above 100 act as 100). The block steps a 32-bit
// phase accumulator by phase_increment, reads a half-sine table of TABLE_ENTRIES
// entries and returns compare = ((sine*pwm_period)>>12)*amp>>10 with
// amp = pct*1024/100, plus the active channel (A/B) and a sync level that toggles
// at each phase wrap; the channel flips on the tick after a wrap. The phase is
// updated at the accepting edge; the result then comes from one registered
// table read and two passes through one shared multiplier. A new request is
// taken only while the block is idle, so a request is not taken before the last
// result is loaded into the output register; a stalled result holds the block
// in its last step. Configuration writes are always taken (cfg_ready is high)
// and must be made while no request is in work. No clearing pass follows reset.
// Depends on spwm_pkg, spwm_rom and spwm_mul_unit.
module spwm_half_sine_generator #(
  parameter int unsigned TABLE_ENTRIES = 512
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [spwm_pkg::PCT_W-1:0]          in_amplitude_percent,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [spwm_pkg::CMP_W-1:0]          out_compare_value,
  output logic                                out_channel_b_active,
  output logic                                out_sync_level,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [spwm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spwm_pkg::PHASE_W-1:0]        cfg_data
);

  spwm_pkg::seq_state_t state_r, state_nxt;

  logic [spwm_pkg::PHASE_W-1:0]    phase_inc_r;
  logic [spwm_pkg::PERIOD_W-1:0]   pwm_period_r;
  logic [spwm_pkg::PHASE_W-1:0]    phase_r, phase_nxt;
  logic                            prev_top_r, swap_r, chan_b_r, sync_r;
  logic [spwm_pkg::AMP_W-1:0]      amp_r;
  logic [spwm_pkg::SCALED_W-1:0]   scaled_r;
  logic                            out_valid_r;
  logic [spwm_pkg::CMP_W-1:0]      out_cmp_r;
  logic                            out_chan_r, out_sync_r;

  logic                            in_take, out_take, out_load;
  logic [spwm_pkg::PCT_W-1:0]      pct_sat;
  logic [spwm_pkg::AMP_PROD_W-1:0] amp_prod;
  logic [spwm_pkg::ROM_W-1:0]      rom_data;
  logic [spwm_pkg::MUL_P_W-1:0]    product;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spwm_pkg::SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next step and handshake controls
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    out_load  = 1'b0;
    case (state_r)
      spwm_pkg::SEQ_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = spwm_pkg::SEQ_ADDR;
        end
      end
      spwm_pkg::SEQ_ADDR: begin
        state_nxt = spwm_pkg::SEQ_SCALE;
      end
      spwm_pkg::SEQ_SCALE: begin
        state_nxt = spwm_pkg::SEQ_AMP;
      end
      spwm_pkg::SEQ_AMP: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = spwm_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_nxt = spwm_pkg::SEQ_IDLE;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r  <= spwm_pkg::PHASE_INC_RST;
      pwm_period_r <= spwm_pkg::PWM_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spwm_pkg::REG_PHASE_INC:  phase_inc_r  <= cfg_data;
        spwm_pkg::REG_PWM_PERIOD: pwm_period_r <= cfg_data[spwm_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance phase and track wraps on each accepted request
  assign phase_nxt = phase_r + phase_inc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      prev_top_r <= 1'b0;
      swap_r     <= 1'b0;
      chan_b_r   <= 1'b0;
      sync_r     <= 1'b0;
    end else if (in_take) begin
      phase_r    <= phase_nxt;
      prev_top_r <= phase_nxt[spwm_pkg::PHASE_W-1];
      if (swap_r) begin
        chan_b_r <= !chan_b_r;
        swap_r   <= 1'b0;
      end else if (prev_top_r && !phase_nxt[spwm_pkg::PHASE_W-1]) begin
        swap_r <= 1'b1;
        sync_r <= !sync_r;
      end
    end
  end

  // Saturate percent and scale to 0..1024
  assign pct_sat  = (in_amplitude_percent > spwm_pkg::PCT_MAX) ? spwm_pkg::PCT_MAX
                                                              : in_amplitude_percent;
  assign amp_prod = spwm_pkg::AMP_PROD_W'(pct_sat) * spwm_pkg::AMP_RECIP;

  always_ff @(posedge clk) begin
    if (in_take) begin
      amp_r <= amp_prod[spwm_pkg::AMP_PROD_W-1 -: spwm_pkg::AMP_W];
    end
  end

  spwm_rom #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_rom (
    .clk      (clk),
    .phase    (phase_r),
    .rom_data (rom_data)
  );

  spwm_mul_unit u_mul (
    .step       (state_r),
    .rom_data   (rom_data),
    .pwm_period (pwm_period_r),
    .scaled     (scaled_r),
    .amp        (amp_r),
    .product    (product)
  );

  // Hold the period-scaled sine: (rom*period) >> 12
  always_ff @(posedge clk) begin
    if (state_r == spwm_pkg::SEQ_SCALE) begin
      scaled_r <= product[12 +: spwm_pkg::SCALED_W];
    end
  end

  // Output register: load (scaled*amp) >> 10, drop on take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cmp_r  <= product[10 +: spwm_pkg::CMP_W];
      out_chan_r <= chan_b_r;
      out_sync_r <= sync_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_compare_value    = out_cmp_r;
  assign out_channel_b_active = out_chan_r;
  assign out_sync_level       = out_sync_r;

endmodule
